### rtl/qadd_pkg.sv
package qadd_pkg;

    localparam int unsigned ZP_W     = 8;
    localparam int unsigned MULT_W   = 31;
    localparam int unsigned SHIFT_W  = 5;
    localparam int unsigned CFG_W    = 31;
    localparam int unsigned IDX_W    = 3;
    localparam int unsigned SCALED_W = 29;

    typedef enum logic [IDX_W-1:0] {
        REG_LEFT_ZP    = 3'd0,
        REG_RIGHT_ZP   = 3'd1,
        REG_OUT_ZP     = 3'd2,
        REG_LEFT_MULT  = 3'd3,
        REG_RIGHT_MULT = 3'd4,
        REG_OUT_MULT   = 3'd5,
        REG_SHIFTS     = 3'd6
    } t_reg_idx;

    typedef struct packed {
        logic [ZP_W-1:0]    left_zp;
        logic [ZP_W-1:0]    right_zp;
        logic [ZP_W-1:0]    out_zp;
        logic [MULT_W-1:0]  left_mult;
        logic [MULT_W-1:0]  right_mult;
        logic [MULT_W-1:0]  out_mult;
        logic [SHIFT_W-1:0] lhs_rshift;
        logic [SHIFT_W-1:0] right_shift;
        logic [SHIFT_W-1:0] out_shift;
    } t_qadd_cfg;

    // rounding right shift, ties away from zero
    function automatic logic signed [31:0] qadd_round_shift(
        input logic signed [31:0] x,
        input logic [SHIFT_W-1:0] s
    );
        logic [31:0]        mask;
        logic [31:0]        rem;
        logic [31:0]        thr;
        logic signed [31:0] q;
        mask = (32'd1 << s) - 32'd1;
        rem  = x & mask;
        q    = x >>> s;
        thr  = (mask >> 1) + {31'd0, x[31]};
        return q + $signed({31'd0, (rem > thr)});
    endfunction

endpackage

### rtl/qadd_cfg_regs.sv
module qadd_cfg_regs
    import qadd_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0] i_cfg_data,
    output t_qadd_cfg        o_cfg
);

    t_qadd_cfg r_cfg;
    t_qadd_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_LEFT_ZP:    n_cfg.left_zp    = i_cfg_data[ZP_W-1:0];
                REG_RIGHT_ZP:   n_cfg.right_zp   = i_cfg_data[ZP_W-1:0];
                REG_OUT_ZP:     n_cfg.out_zp     = i_cfg_data[ZP_W-1:0];
                REG_LEFT_MULT:  n_cfg.left_mult  = i_cfg_data[MULT_W-1:0];
                REG_RIGHT_MULT: n_cfg.right_mult = i_cfg_data[MULT_W-1:0];
                REG_OUT_MULT:   n_cfg.out_mult   = i_cfg_data[MULT_W-1:0];
                REG_SHIFTS: begin
                    n_cfg.lhs_rshift  = i_cfg_data[4:0];
                    n_cfg.right_shift = i_cfg_data[9:5];
                    n_cfg.out_shift   = i_cfg_data[14:10];
                end
                default: n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

### rtl/qadd_in_scale.sv
module qadd_in_scale
    import qadd_pkg::*;
(
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    input  logic [7:0]                 i_value,
    input  logic [ZP_W-1:0]            i_zero_point,
    input  logic [MULT_W-1:0]          i_mult,
    input  logic [SHIFT_W-1:0]         i_shift,
    output logic                       o_valid,
    output logic signed [SCALED_W-1:0] o_scaled
);

    logic [3:0]                 r_vld;
    logic signed [8:0]          r_diff;
    logic signed [40:0]         r_prod;
    logic signed [SCALED_W-1:0] r_high;
    logic signed [SCALED_W-1:0] r_scaled;

    logic signed [8:0]  n_diff;
    logic signed [40:0] n_prod;
    logic signed [40:0] n_round;
    logic signed [31:0] n_shifted;

    // the shift by 20 folds into the doubling high multiply: (p + 2^10) >> 11
    always_comb begin
        n_diff    = $signed({1'b0, i_value}) - $signed({1'b0, i_zero_point});
        n_prod    = r_diff * $signed({1'b0, i_mult});
        n_round   = r_prod + 41'sd1024;
        n_shifted = qadd_round_shift({{(32-SCALED_W){r_high[SCALED_W-1]}}, r_high},
                                     i_shift);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        r_diff   <= n_diff;
        r_prod   <= n_prod;
        r_high   <= n_round[SCALED_W+10:11];
        r_scaled <= n_shifted[SCALED_W-1:0];
    end

    assign o_valid  = r_vld[3];
    assign o_scaled = r_scaled;

endmodule

### rtl/qadd_out_scale.sv
module qadd_out_scale
    import qadd_pkg::*;
(
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    input  logic signed [SCALED_W-1:0] i_lhs,
    input  logic signed [SCALED_W-1:0] i_rhs,
    input  logic [ZP_W-1:0]            i_zero_point,
    input  logic [MULT_W-1:0]          i_mult,
    input  logic [SHIFT_W-1:0]         i_shift,
    output logic                       o_valid,
    output logic [7:0]                 o_value
);

    logic [3:0]           r_vld;
    logic signed [29:0]   r_sum;
    logic signed [61:0]   r_prod;
    logic signed [31:0]   r_high;
    logic [7:0]           r_value;

    logic signed [29:0] n_sum;
    logic signed [61:0] n_prod;
    logic signed [61:0] n_round;
    logic signed [31:0] n_res;
    logic [7:0]         n_value;

    always_comb begin
        n_sum   = {i_lhs[SCALED_W-1], i_lhs} + {i_rhs[SCALED_W-1], i_rhs};
        n_prod  = r_sum * $signed({1'b0, i_mult});
        n_round = r_prod + (62'sd1 <<< 30);
        n_res   = qadd_round_shift(r_high, i_shift) + $signed({24'd0, i_zero_point});
        if (n_res[31]) begin
            n_value = 8'd0;
        end else if (n_res > 32'sd255) begin
            n_value = 8'd255;
        end else begin
            n_value = n_res[7:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        r_sum   <= n_sum;
        r_prod  <= n_prod;
        r_high  <= {n_round[61], n_round[61:31]};
        r_value <= n_value;
    end

    assign o_valid = r_vld[3];
    assign o_value = r_value;

endmodule

### rtl/quantized_uint8_add_core.sv
// Quantized uint8 elementwise add. A pair is taken on every cycle that start
// is high (busy is never raised) and its sum leaves on o_sum_value with
// o_strobe once it has passed both rescale stages; the receiver cannot
// stall, so there is no back-pressure anywhere in the pipe. Each rescale
// stage is a chain of registered steps: zero-point removal, operand multiply,
// doubling high part and rounding shift on each operand in parallel, then
// sum, output multiply, high part and rounding shift with zero-point add and
// clamp. Write the configuration registers only while no pair is in flight.
module quantized_uint8_add_core
    import qadd_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    output logic             busy,
    input  logic [7:0]       i_lhs_value,
    input  logic [7:0]       i_rhs_value,
    input  logic             i_cfg_we,
    input  logic [IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0] i_cfg_data,
    output logic             o_strobe,
    output logic [7:0]       o_sum_value
);

    localparam int unsigned LATENCY = 8;

    t_qadd_cfg                  cfg;
    logic                       accept;
    logic                       lhs_vld;
    logic                       rhs_vld;
    logic signed [SCALED_W-1:0] lhs_scaled;
    logic signed [SCALED_W-1:0] rhs_scaled;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    qadd_cfg_regs u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg)
    );

    qadd_in_scale u_lhs (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (accept),
        .i_value      (i_lhs_value),
        .i_zero_point (cfg.left_zp),
        .i_mult       (cfg.left_mult),
        .i_shift      (cfg.lhs_rshift),
        .o_valid      (lhs_vld),
        .o_scaled     (lhs_scaled)
    );

    qadd_in_scale u_rhs (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (accept),
        .i_value      (i_rhs_value),
        .i_zero_point (cfg.right_zp),
        .i_mult       (cfg.right_mult),
        .i_shift      (cfg.right_shift),
        .o_valid      (rhs_vld),
        .o_scaled     (rhs_scaled)
    );

    qadd_out_scale u_out (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (lhs_vld && rhs_vld),
        .i_lhs        (lhs_scaled),
        .i_rhs        (rhs_scaled),
        .i_zero_point (cfg.out_zp),
        .i_mult       (cfg.out_mult),
        .i_shift      (cfg.out_shift),
        .o_valid      (o_strobe),
        .o_value      (o_sum_value)
    );

    a_beat_delivered: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |-> ##LATENCY o_strobe)
        else $error("accepted beat did not reach the output");

    a_no_phantom_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(accept, LATENCY))
        else $error("output strobe without an accepted beat");

    a_lanes_aligned: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        lhs_vld == rhs_vld)
        else $error("operand lanes out of step");

    a_zero_out_mult: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && cfg.out_mult == '0) |-> o_sum_value == cfg.out_zp)
        else $error("zero output multiplier must give the output zero point");

endmodule

### tb/sv/quantized_uint8_add_core_tb.sv
`timescale 1ns / 1ps

module quantized_uint8_add_core_tb
    import qadd_pkg::*;
();

    localparam logic [IDX_W-1:0] REG_SPARE = 3'd7;
    localparam int unsigned      SCALE_UP  = 20;
    localparam int unsigned      PHASES    = 23;
    localparam int unsigned      PER_PHASE = 50;

    typedef struct packed {
        logic [7:0] lhs;
        logic [7:0] rhs;
    } t_pair;

    logic             i_clk       = 1'b0;
    logic             i_rst_n     = 1'b0;
    logic             start       = 1'b0;
    logic             busy;
    logic [7:0]       i_lhs_value = '0;
    logic [7:0]       i_rhs_value = '0;
    logic             i_cfg_we    = 1'b0;
    logic [IDX_W-1:0] i_cfg_idx   = '0;
    logic [CFG_W-1:0] i_cfg_data  = '0;
    logic             o_strobe;
    logic [7:0]       o_sum_value;

    t_pair       pending_pairs[$];
    logic [7:0]  sum_expected[$];
    t_qadd_cfg   cfg_now      = '0;
    int unsigned pairs_queued = 0;
    int unsigned pairs_taken  = 0;
    int unsigned mismatches   = 0;
    int unsigned gap_left     = 0;
    bit          burst        = 1'b0;
    bit          took         = 1'b0;

    quantized_uint8_add_core i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_lhs_value (i_lhs_value),
        .i_rhs_value (i_rhs_value),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .o_strobe    (o_strobe),
        .o_sum_value (o_sum_value)
    );

    initial begin : clock_gen
        forever #5 i_clk = ~i_clk;
    end

    function automatic longint high_part(longint x, longint m);
        longint prod;
        longint nudge;
        prod  = x * m;
        nudge = (prod >= 0) ? (64'sd1 <<< 30) : (64'sd1 - (64'sd1 <<< 30));
        return (prod + nudge) / (64'sd1 <<< 31);
    endfunction

    function automatic longint round_shift(longint x, int s);
        longint pw;
        longint mask;
        longint rem;
        longint thr;
        pw   = 64'sd1 <<< s;
        mask = pw - 64'sd1;
        rem  = x & mask;
        thr  = (mask >>> 1) + ((x < 0) ? 64'sd1 : 64'sd0);
        return (x - rem) / pw + ((rem > thr) ? 64'sd1 : 64'sd0);
    endfunction

    function automatic logic [7:0] predict_sum(logic [7:0] lhs, logic [7:0] rhs);
        longint a;
        longint b;
        longint sa;
        longint sb;
        longint zp;
        longint r;
        a  = lhs;
        zp = cfg_now.left_zp;
        a  = a - zp;
        b  = rhs;
        zp = cfg_now.right_zp;
        b  = b - zp;
        sa = round_shift(high_part(a <<< SCALE_UP, cfg_now.left_mult), cfg_now.lhs_rshift);
        sb = round_shift(high_part(b <<< SCALE_UP, cfg_now.right_mult), cfg_now.right_shift);
        zp = cfg_now.out_zp;
        r  = round_shift(high_part(sa + sb, cfg_now.out_mult), cfg_now.out_shift) + zp;
        if (r < 0) begin
            r = 0;
        end else if (r > 255) begin
            r = 255;
        end
        return r[7:0];
    endfunction

    function automatic logic [MULT_W-1:0] wild_mult();
        case ($urandom_range(0, 3))
            0: return '0;
            1: return '1;
            default: return MULT_W'($urandom);
        endcase
    endfunction

    task automatic report_mismatch(string msg);
        $display("mismatch at %0t: %s", $time, msg);
        mismatches++;
    endtask

    task automatic write_reg(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] data);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        case (idx)
            REG_LEFT_ZP:    cfg_now.left_zp    = data[ZP_W-1:0];
            REG_RIGHT_ZP:   cfg_now.right_zp   = data[ZP_W-1:0];
            REG_OUT_ZP:     cfg_now.out_zp     = data[ZP_W-1:0];
            REG_LEFT_MULT:  cfg_now.left_mult  = data[MULT_W-1:0];
            REG_RIGHT_MULT: cfg_now.right_mult = data[MULT_W-1:0];
            REG_OUT_MULT:   cfg_now.out_mult   = data[MULT_W-1:0];
            REG_SHIFTS: begin
                {cfg_now.out_shift, cfg_now.right_shift, cfg_now.lhs_rshift} =
                    data[3*SHIFT_W-1:0];
            end
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic random_config();
        bit tame;
        tame = ($urandom_range(0, 3) != 0);
        if (tame) begin
            write_reg(REG_LEFT_ZP, CFG_W'($urandom_range(0, 255)));
            write_reg(REG_RIGHT_ZP, CFG_W'($urandom_range(0, 255)));
            write_reg(REG_OUT_ZP, CFG_W'($urandom_range(0, 255)));
            write_reg(REG_LEFT_MULT, CFG_W'($urandom_range(32'h4000_0000, 32'h7FFF_FFFF)));
            write_reg(REG_RIGHT_MULT, CFG_W'($urandom_range(32'h4000_0000, 32'h7FFF_FFFF)));
            write_reg(REG_OUT_MULT, CFG_W'($urandom_range(32'h4000_0000, 32'h7FFF_FFFF)));
            write_reg(REG_SHIFTS, {16'd0, 5'($urandom_range(17, 21)),
                                   5'($urandom_range(0, 2)), 5'($urandom_range(0, 2))});
        end else begin
            write_reg(REG_LEFT_ZP, CFG_W'($urandom));
            write_reg(REG_RIGHT_ZP, CFG_W'($urandom));
            write_reg(REG_OUT_ZP, CFG_W'($urandom));
            write_reg(REG_LEFT_MULT, wild_mult());
            write_reg(REG_RIGHT_MULT, wild_mult());
            write_reg(REG_OUT_MULT, wild_mult());
            write_reg(REG_SHIFTS, CFG_W'($urandom));
        end
        if ($urandom_range(0, 3) == 0) begin
            write_reg(REG_SPARE, CFG_W'($urandom));
        end
    endtask

    task automatic queue_pair(logic [7:0] lhs, logic [7:0] rhs);
        pending_pairs.push_back('{lhs: lhs, rhs: rhs});
        pairs_queued++;
    endtask

    task automatic drain();
        while (pairs_taken != pairs_queued || sum_expected.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    always @(negedge i_clk) begin : driver
        t_pair p;
        if (!i_rst_n) begin
            start <= 1'b0;
        end else if (!start || took) begin
            if (gap_left != 0) begin
                start    <= 1'b0;
                gap_left = gap_left - 1;
            end else if (pending_pairs.size() != 0) begin
                p           = pending_pairs.pop_front();
                start       <= 1'b1;
                i_lhs_value <= p.lhs;
                i_rhs_value <= p.rhs;
                gap_left    = burst ? 0 : $urandom_range(0, 5);
            end else begin
                start <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin : monitor
        logic [7:0] want;
        took <= i_rst_n && start && !busy;
        if (i_rst_n) begin
            if (start && !busy) begin
                sum_expected.push_back(predict_sum(i_lhs_value, i_rhs_value));
                pairs_taken++;
            end
            if (o_strobe) begin
                if (sum_expected.size() == 0) begin
                    report_mismatch($sformatf("beat with nothing pending, sum %0d",
                                              o_sum_value));
                end else begin
                    want = sum_expected.pop_front();
                    if (o_sum_value !== want) begin
                        report_mismatch($sformatf("sum %0d, want %0d", o_sum_value, want));
                    end
                end
            end
        end
    end

    initial begin : stimulus
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // zero multipliers after reset: every sum is the output zero point
        queue_pair(8'd0, 8'd0);
        queue_pair(8'd255, 8'd255);
        queue_pair(8'd0, 8'd255);
        queue_pair(8'd255, 8'd0);
        drain();

        // operand shifts of zero, half-scale operands
        write_reg(REG_LEFT_ZP, 31'd128);
        write_reg(REG_RIGHT_ZP, 31'd128);
        write_reg(REG_OUT_ZP, 31'd128);
        write_reg(REG_LEFT_MULT, 31'h4000_0000);
        write_reg(REG_RIGHT_MULT, 31'h4000_0000);
        write_reg(REG_OUT_MULT, 31'h7FFF_FFFF);
        write_reg(REG_SHIFTS, {16'd0, 5'd20, 5'd0, 5'd0});
        queue_pair(8'd128, 8'd128);
        queue_pair(8'd255, 8'd255);
        queue_pair(8'd0, 8'd0);
        queue_pair(8'd255, 8'd0);
        queue_pair(8'd0, 8'd255);
        queue_pair(8'd200, 8'd60);
        drain();

        // sums far outside the output range: clamp both ways
        write_reg(REG_LEFT_ZP, 31'd255);
        write_reg(REG_RIGHT_ZP, 31'd0);
        write_reg(REG_OUT_ZP, 31'd0);
        write_reg(REG_SHIFTS, {16'd0, 5'd18, 5'd0, 5'd0});
        queue_pair(8'd0, 8'd0);
        queue_pair(8'd255, 8'd255);
        queue_pair(8'd128, 8'd64);
        queue_pair(8'd0, 8'd255);
        drain();

        // every register at its top value
        write_reg(REG_LEFT_ZP, 31'd255);
        write_reg(REG_RIGHT_ZP, 31'd255);
        write_reg(REG_OUT_ZP, 31'd255);
        write_reg(REG_LEFT_MULT, 31'h7FFF_FFFF);
        write_reg(REG_RIGHT_MULT, 31'h7FFF_FFFF);
        write_reg(REG_OUT_MULT, 31'h7FFF_FFFF);
        write_reg(REG_SHIFTS, 31'h0000_7FFF);
        queue_pair(8'd0, 8'd0);
        queue_pair(8'd255, 8'd255);
        queue_pair(8'd0, 8'd255);
        queue_pair(8'd255, 8'd0);
        drain();

        // unused index: must leave the settings alone
        write_reg(REG_SPARE, 31'h0000_0000);
        queue_pair(8'd17, 8'd240);
        queue_pair(8'd255, 8'd1);
        drain();

        for (int ph = 0; ph < PHASES; ph++) begin
            random_config();
            burst = ($urandom_range(0, 3) == 0);
            repeat (PER_PHASE) queue_pair(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
            drain();
        end

        repeat (20) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("quantized_uint8_add_core_tb passed");
        end else begin
            $display("quantized_uint8_add_core_tb failed");
        end
        $finish;
    end

    initial begin : watchdog
        #2_000_000;
        $display("quantized_uint8_add_core_tb failed");
        $finish;
    end

endmodule
